// ===== design/evq_pkg.sv =====
// Package for the event queue timer scheduler: opcodes, status codes,
// sequencer states and shared structs. No dependencies.
package evq_pkg;

   localparam logic [1:0] KIND_POST   = 2'd0;
   localparam logic [1:0] KIND_POP    = 2'd1;
   localparam logic [1:0] KIND_CANCEL = 2'd2;
   localparam logic [1:0] KIND_TICK   = 2'd3;

   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_FULL    = 2'd1;
   localparam logic [1:0] STAT_NO_SLOT = 2'd2;
   localparam logic [1:0] STAT_ZERO_ID = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_POST,
      ST_POST_SCAN,
      ST_POP,
      ST_POP_DATA,
      ST_CANCEL,
      ST_TICK_SCAN,
      ST_TICK_EXEC,
      ST_DONE
   } state_type;

   // one timer slot as stored in the slot memory
   typedef struct packed {
      logic [15:0] rem;
      logic [7:0]  id;
      logic [15:0] hw;
   } slot_entry_type;

   // ring buffer requests from the sequencer
   typedef struct packed {
      logic        push;
      logic        pop;
      logic [7:0]  id;
      logic [15:0] hw;
   } ring_ctl_type;

endpackage

// ===== design/evq_if.sv =====
// Request and response channel interfaces (valid/ready plus payload).
// No dependencies.
interface evq_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  event_id;
   logic [15:0] handler;
   logic [15:0] delay;
   logic [2:0]  timer_index;

   modport source (output valid, kind, event_id, handler, delay, timer_index,
                   input ready);
   modport sink   (input valid, kind, event_id, handler, delay, timer_index,
                   output ready);
endinterface

interface evq_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [3:0]  timer_id;
   logic [7:0]  out_event_id;
   logic [15:0] out_handler;
   logic [3:0]  fired_count;
   logic [3:0]  queued_now;
   logic [3:0]  queued_peak;
   logic [3:0]  timers_now;
   logic [3:0]  timers_peak;

   modport source (output valid, status, timer_id, out_event_id, out_handler,
                   fired_count, queued_now, queued_peak, timers_now,
                   timers_peak,
                   input ready);
   modport sink   (input valid, status, timer_id, out_event_id, out_handler,
                   fired_count, queued_now, queued_peak, timers_now,
                   timers_peak,
                   output ready);
endinterface

// ===== design/evq_ring.sv =====
// Event ring buffer: id/handler memory with pointers, fill and peak count.
// Depends on evq_pkg.
module evq_ring #(
   parameter int EVENT_DEPTH = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  evq_pkg::ring_ctl_type           ctl,
   output logic                            full,
   output logic                            empty,
   output logic [$clog2(EVENT_DEPTH)-1:0]  fill,
   output logic [$clog2(EVENT_DEPTH)-1:0]  peak,
   output logic [7:0]                      rd_id,
   output logic [15:0]                     rd_hw
);
   import evq_pkg::*;

   localparam int PW = $clog2(EVENT_DEPTH);

   logic [7:0]    mem_id [EVENT_DEPTH];
   logic [15:0]   mem_hw [EVENT_DEPTH];
   logic [PW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [PW-1:0] fill_ff, fill_in, peak_ff, peak_in;
   logic [7:0]    rd_id_ff;
   logic [15:0]   rd_hw_ff;

   // capacity is one less than the depth
   assign full  = (fill_ff == PW'(EVENT_DEPTH - 1));
   assign empty = (fill_ff == '0);
   assign fill  = fill_ff;
   assign peak  = peak_ff;
   assign rd_id = rd_id_ff;
   assign rd_hw = rd_hw_ff;

   always_comb begin
      wp_in   = wp_ff;
      rp_in   = rp_ff;
      fill_in = fill_ff;
      peak_in = peak_ff;
      if (ctl.push && !full) begin
         wp_in   = (wp_ff == PW'(EVENT_DEPTH - 1)) ? '0 : wp_ff + PW'(1);
         fill_in = fill_ff + PW'(1);
         if (fill_in > peak_ff) begin
            peak_in = fill_in;
         end
      end else if (ctl.pop && !empty) begin
         rp_in   = (rp_ff == PW'(EVENT_DEPTH - 1)) ? '0 : rp_ff + PW'(1);
         fill_in = fill_ff - PW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff   <= '0;
         rp_ff   <= '0;
         fill_ff <= '0;
         peak_ff <= '0;
      end else begin
         wp_ff   <= wp_in;
         rp_ff   <= rp_in;
         fill_ff <= fill_in;
         peak_ff <= peak_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.push && !full) begin
         mem_id[wp_ff] <= ctl.id;
         mem_hw[wp_ff] <= ctl.hw;
      end
      if (ctl.pop) begin
         rd_id_ff <= mem_id[rp_ff];
         rd_hw_ff <= mem_hw[rp_ff];
      end
   end

endmodule

// ===== design/event_queue_timer_scheduler.sv =====
// Event queue with software timer slots, run by a small sequencer.
// Depends on evq_pkg, evq_if (evq_req_if, evq_rsp_if) and evq_ring.
//
// Usage:
//   req_chan carries one command transaction (post, pop, cancel, tick);
//   rsp_chan returns exactly one result transaction per command, in order.
//   csr_wr_en/csr_wr_data write tick_interval; write only while idle.
// Sequence: a delayed post scans the slots for the lowest free one; a
//   tick walks all TIMER_SLOTS slots in order (idle slots pass through
//   the scan state only, active ones also through the exec state: slot
//   memory read, then the shared compare/subtract unit). A tick at
//   interval 0 skips the scan. Zero-delay post, zero id, cancel and pop
//   need no scan.
// Throughput: one command in flight; req_chan.ready is high only while the
//   sequencer is idle. The finished result sits in an output register, so
//   the next command is taken while the previous result waits.
// Stall: if rsp_chan is stalled and a second result is done, the sequencer
//   holds in its done state until the output register drains.
// Reset: queue empty, all slots free, counters and peaks zero,
//   tick_interval = 1. No clearing pass: slot validity lives in flip-flops.
module event_queue_timer_scheduler #(
   parameter int EVENT_DEPTH = 16,
   parameter int TIMER_SLOTS = 8
) (
   input  logic        clock,
   input  logic        reset,
   evq_req_if.sink     req_chan,
   evq_rsp_if.source   rsp_chan,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);
   import evq_pkg::*;

   localparam int FW = $clog2(EVENT_DEPTH);
   localparam int SW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
   localparam int AW = $clog2(TIMER_SLOTS + 1);

   // sequencer control
   state_type        state_ff, state_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [TIMER_SLOTS-1:0] slot_valid_ff, slot_valid_in;
   logic [AW-1:0]    active_ff, active_in, active_peak_ff, active_peak_in;
   logic [15:0]      tick_interval_ff, tick_interval_in;

   // latched command and working values
   logic [1:0]       kind_ff, kind_in;
   logic [7:0]       id_ff, id_in;
   logic [15:0]      hw_ff, hw_in;
   logic [15:0]      delay_ff, delay_in;
   logic [2:0]       tidx_ff, tidx_in;
   logic [SW-1:0]    idx_ff, idx_in;
   logic [1:0]       status_ff, status_in;
   logic [3:0]       timer_id_ff, timer_id_in;
   logic [AW-1:0]    fired_ff, fired_in;
   logic [7:0]       oid_ff, oid_in;
   logic [15:0]      ohw_ff, ohw_in;

   // slot memory
   slot_entry_type   slot_mem [TIMER_SLOTS];
   slot_entry_type   slot_rd_ff;
   slot_entry_type   slot_wdata;
   logic             slot_we;
   logic             rsp_load;

   // ring buffer
   ring_ctl_type     ring_ctl;
   logic             ring_full, ring_empty;
   logic [FW-1:0]    ring_fill, ring_peak;
   logic [7:0]       ring_rd_id;
   logic [15:0]      ring_rd_hw;

   // output register
   logic [1:0]       r_status_ff;
   logic [3:0]       r_timer_id_ff, r_fired_ff, r_qnow_ff, r_qpeak_ff;
   logic [3:0]       r_tnow_ff, r_tpeak_ff;
   logic [7:0]       r_oid_ff;
   logic [15:0]      r_ohw_ff;

   logic             idx_last;
   logic             cancel_hit;
   logic [SW-1:0]    cancel_idx;

   evq_ring #(.EVENT_DEPTH(EVENT_DEPTH)) u_ring (
      .clock (clock),
      .reset (reset),
      .ctl   (ring_ctl),
      .full  (ring_full),
      .empty (ring_empty),
      .fill  (ring_fill),
      .peak  (ring_peak),
      .rd_id (ring_rd_id),
      .rd_hw (ring_rd_hw)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = r_status_ff;
   assign rsp_chan.timer_id     = r_timer_id_ff;
   assign rsp_chan.out_event_id = r_oid_ff;
   assign rsp_chan.out_handler  = r_ohw_ff;
   assign rsp_chan.fired_count  = r_fired_ff;
   assign rsp_chan.queued_now   = r_qnow_ff;
   assign rsp_chan.queued_peak  = r_qpeak_ff;
   assign rsp_chan.timers_now   = r_tnow_ff;
   assign rsp_chan.timers_peak  = r_tpeak_ff;

   assign idx_last   = (idx_ff == SW'(TIMER_SLOTS - 1));
   assign cancel_idx = SW'(tidx_ff);
   // out-of-range cancel index is ignored
   assign cancel_hit = (32'(tidx_ff) < TIMER_SLOTS) && slot_valid_ff[cancel_idx];

   always_comb begin
      state_in         = state_ff;
      rsp_valid_in     = rsp_valid_ff;
      slot_valid_in    = slot_valid_ff;
      active_in        = active_ff;
      active_peak_in   = active_peak_ff;
      tick_interval_in = csr_wr_en ? csr_wr_data : tick_interval_ff;
      kind_in          = kind_ff;
      id_in            = id_ff;
      hw_in            = hw_ff;
      delay_in         = delay_ff;
      tidx_in          = tidx_ff;
      idx_in           = idx_ff;
      status_in        = status_ff;
      timer_id_in      = timer_id_ff;
      fired_in         = fired_ff;
      oid_in           = oid_ff;
      ohw_in           = ohw_ff;
      ring_ctl         = '{push: 1'b0, pop: 1'b0, id: id_ff, hw: hw_ff};
      slot_we          = 1'b0;
      slot_wdata       = '{rem: delay_ff, id: id_ff, hw: hw_ff};
      rsp_load         = 1'b0;

      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               kind_in     = req_chan.kind;
               id_in       = req_chan.event_id;
               hw_in       = req_chan.handler;
               delay_in    = req_chan.delay;
               tidx_in     = req_chan.timer_index;
               idx_in      = '0;
               status_in   = STAT_OK;
               timer_id_in = 4'(TIMER_SLOTS);
               fired_in    = '0;
               oid_in      = '0;
               ohw_in      = '0;
               unique case (req_chan.kind)
                  KIND_POST:   state_in = ST_POST;
                  KIND_POP:    state_in = ST_POP;
                  KIND_CANCEL: state_in = ST_CANCEL;
                  KIND_TICK:   state_in = (tick_interval_ff == '0) ? ST_DONE
                                                                   : ST_TICK_SCAN;
                  default:     state_in = ST_DONE;
               endcase
            end
         end
         ST_POST: begin
            priority if (id_ff == '0) begin
               status_in = STAT_ZERO_ID;
               state_in  = ST_DONE;
            end else if (delay_ff == '0) begin
               if (ring_full) begin
                  status_in = STAT_FULL;
               end else begin
                  ring_ctl.push = 1'b1;
               end
               state_in = ST_DONE;
            end else begin
               state_in = ST_POST_SCAN;
            end
         end
         ST_POST_SCAN: begin
            // lowest free slot, one slot per cycle
            priority if (!slot_valid_ff[idx_ff]) begin
               slot_we               = 1'b1;
               slot_valid_in[idx_ff] = 1'b1;
               active_in             = active_ff + AW'(1);
               if (active_in > active_peak_ff) begin
                  active_peak_in = active_in;
               end
               timer_id_in = 4'(idx_ff);
               state_in    = ST_DONE;
            end else if (idx_last) begin
               status_in = STAT_NO_SLOT;
               state_in  = ST_DONE;
            end else begin
               idx_in = idx_ff + SW'(1);
            end
         end
         ST_POP: begin
            if (ring_empty) begin
               state_in = ST_DONE;
            end else begin
               ring_ctl.pop = 1'b1;
               state_in     = ST_POP_DATA;
            end
         end
         ST_POP_DATA: begin
            oid_in   = ring_rd_id;
            ohw_in   = ring_rd_hw;
            state_in = ST_DONE;
         end
         ST_CANCEL: begin
            if (cancel_hit) begin
               slot_valid_in[cancel_idx] = 1'b0;
               active_in                 = active_ff - AW'(1);
            end
            state_in = ST_DONE;
         end
         ST_TICK_SCAN: begin
            // slot memory is read at idx_ff every cycle
            priority if (slot_valid_ff[idx_ff]) begin
               state_in = ST_TICK_EXEC;
            end else if (idx_last) begin
               state_in = ST_DONE;
            end else begin
               idx_in = idx_ff + SW'(1);
            end
         end
         ST_TICK_EXEC: begin
            slot_wdata = slot_rd_ff;
            priority if (slot_rd_ff.rem > tick_interval_ff) begin
               slot_we         = 1'b1;
               slot_wdata.rem  = slot_rd_ff.rem - tick_interval_ff;
            end else if (!ring_full) begin
               ring_ctl.push         = 1'b1;
               ring_ctl.id           = slot_rd_ff.id;
               ring_ctl.hw           = slot_rd_ff.hw;
               slot_valid_in[idx_ff] = 1'b0;
               active_in             = active_ff - AW'(1);
               fired_in              = fired_ff + AW'(1);
            end else begin
               // queue full: hold at one and retry next tick
               slot_we        = 1'b1;
               slot_wdata.rem = 16'd1;
               status_in      = STAT_FULL;
            end
            if (idx_last) begin
               state_in = ST_DONE;
            end else begin
               idx_in   = idx_ff + SW'(1);
               state_in = ST_TICK_SCAN;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         rsp_valid_ff     <= 1'b0;
         slot_valid_ff    <= '0;
         active_ff        <= '0;
         active_peak_ff   <= '0;
         tick_interval_ff <= 16'd1;
      end else begin
         state_ff         <= state_in;
         rsp_valid_ff     <= rsp_valid_in;
         slot_valid_ff    <= slot_valid_in;
         active_ff        <= active_in;
         active_peak_ff   <= active_peak_in;
         tick_interval_ff <= tick_interval_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      id_ff       <= id_in;
      hw_ff       <= hw_in;
      delay_ff    <= delay_in;
      tidx_ff     <= tidx_in;
      idx_ff      <= idx_in;
      status_ff   <= status_in;
      timer_id_ff <= timer_id_in;
      fired_ff    <= fired_in;
      oid_ff      <= oid_in;
      ohw_ff      <= ohw_in;
      if (rsp_load) begin
         r_status_ff   <= status_ff;
         r_timer_id_ff <= timer_id_ff;
         r_oid_ff      <= oid_ff;
         r_ohw_ff      <= ohw_ff;
         r_fired_ff    <= 4'(fired_ff);
         r_qnow_ff     <= 4'(ring_fill);
         r_qpeak_ff    <= 4'(ring_peak);
         r_tnow_ff     <= 4'(active_ff);
         r_tpeak_ff    <= 4'(active_peak_ff);
      end
   end

   // slot memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_mem[idx_ff] <= slot_wdata;
      end
      slot_rd_ff <= slot_mem[idx_ff];
   end

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for event_queue_timer_scheduler: clocked driver and monitor
// around an in-file scheduler predictor, with directed and random command streams.
// Depends on evq_pkg, evq_if and the design under design/.
`timescale 1ns / 1ps

module tb;
   import evq_pkg::*;

   localparam int          EVENT_DEPTH  = 16;
   localparam int          TIMER_SLOTS  = 8;
   localparam logic [3:0]  NO_TIMER     = 4'(TIMER_SLOTS);
   localparam int          IDLE_PCT     = 19;    // idle cycles per hundred, each side
   localparam int          HOLD_CYCLES  = 400;   // long receiver hold-off
   localparam int          STALL_LIMIT  = 4000;  // cycles without any handshake
   localparam int          DRAIN_CYCLES = 40;    // longer than the slowest tick
   localparam int          PHASE_ITEMS  = 175;
   localparam int          NUM_PHASES   = 6;
   localparam int          MAX_REPORTS  = 10;

   // one command transaction as offered on req_chan
   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  event_id;
      logic [15:0] handler;
      logic [15:0] delay;
      logic [2:0]  timer_index;
   } evq_cmd_type;

   // one result transaction as seen on rsp_chan
   typedef struct packed {
      logic [1:0]  status;
      logic [3:0]  timer_id;
      logic [7:0]  out_event_id;
      logic [15:0] out_handler;
      logic [3:0]  fired_count;
      logic [3:0]  queued_now;
      logic [3:0]  queued_peak;
      logic [3:0]  timers_now;
      logic [3:0]  timers_peak;
   } evq_result_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_wr_en;
   logic [15:0] csr_wr_data;

   evq_req_if req_bus ();
   evq_rsp_if rsp_bus ();

   event_queue_timer_scheduler #(
      .EVENT_DEPTH (EVENT_DEPTH),
      .TIMER_SLOTS (TIMER_SLOTS)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #2 clock = ~clock;

   // ------------------------------------------------------------------
   // Scheduler shadow state: event ring, timer slots, counters, config.
   // ------------------------------------------------------------------
   logic [7:0]  ring_id   [EVENT_DEPTH];
   logic [15:0] ring_hw   [EVENT_DEPTH];
   logic [3:0]  ring_wr   = '0;
   logic [3:0]  ring_rd   = '0;
   int          ring_fill = 0;
   int          ring_peak = 0;
   logic [15:0] slot_rem  [TIMER_SLOTS] = '{default: '0};
   logic [7:0]  slot_id   [TIMER_SLOTS] = '{default: '0};
   logic [15:0] slot_hw   [TIMER_SLOTS];
   int          timers_active = 0;
   int          timers_high   = 0;
   logic [15:0] tick_iv       = 16'd1;   // tick_interval after reset

   evq_cmd_type    command_backlog [$];     // filled by the sequence, drained by the driver
   evq_result_type expected_results [$];    // predicted, oldest first

   int issued      = 0;
   int accepted    = 0;
   int mismatches  = 0;
   int n_checked   = 0;
   int n_full      = 0;
   int n_no_slot   = 0;
   int n_zero_id   = 0;
   int n_fired     = 0;
   bit steady       = 1'b0;   // no random idling on either side
   bit hold_request = 1'b0;   // ask the monitor for one long hold-off

   // Ring push; the ring keeps one entry spare, so 15 events at most.
   function automatic logic enqueue_event(input logic [7:0] id, input logic [15:0] hw);
      if (ring_fill + 1 >= EVENT_DEPTH)
         return 1'b0;
      ring_id[ring_wr] = id;
      ring_hw[ring_wr] = hw;
      ring_wr = ring_wr + 4'd1;
      ring_fill++;
      if (ring_fill > ring_peak)
         ring_peak = ring_fill;
      return 1'b1;
   endfunction

   // Applies one command to the shadow state and returns the result it must produce.
   function automatic evq_result_type advance_scheduler(input evq_cmd_type c);
      evq_result_type o;
      int             s;
      int             free_slot;
      int             fired;
      o          = '0;
      o.status   = STAT_OK;
      o.timer_id = NO_TIMER;
      fired      = 0;
      case (c.kind)
         KIND_POST: begin
            if (c.event_id == 8'd0) begin
               o.status = STAT_ZERO_ID;
            end else if (c.delay == 16'd0) begin
               if (!enqueue_event(c.event_id, c.handler))
                  o.status = STAT_FULL;
            end else begin
               free_slot = -1;
               for (s = TIMER_SLOTS - 1; s >= 0; s--)
                  if (slot_id[s] == 8'd0)
                     free_slot = s;
               if (free_slot < 0) begin
                  o.status = STAT_NO_SLOT;
               end else begin
                  slot_id[free_slot]  = c.event_id;
                  slot_hw[free_slot]  = c.handler;
                  slot_rem[free_slot] = c.delay;
                  timers_active++;
                  if (timers_active > timers_high)
                     timers_high = timers_active;
                  o.timer_id = 4'(free_slot);
               end
            end
         end
         KIND_POP: begin
            if (ring_fill != 0) begin
               o.out_event_id = ring_id[ring_rd];
               o.out_handler  = ring_hw[ring_rd];
               ring_rd = ring_rd + 4'd1;
               ring_fill--;
            end
         end
         KIND_CANCEL: begin
            // a free slot is left alone, status stays ok
            if (slot_id[c.timer_index] != 8'd0) begin
               slot_id[c.timer_index]  = 8'd0;
               slot_rem[c.timer_index] = 16'd0;
               timers_active--;
            end
         end
         default: begin
            // tick: slot order; expiry at or below zero; full ring parks the slot at 1
            for (s = 0; s < TIMER_SLOTS; s++) begin
               if (slot_id[s] != 8'd0 && tick_iv != 16'd0) begin
                  if (slot_rem[s] > tick_iv) begin
                     slot_rem[s] = slot_rem[s] - tick_iv;
                  end else if (enqueue_event(slot_id[s], slot_hw[s])) begin
                     slot_id[s]  = 8'd0;
                     slot_rem[s] = 16'd0;
                     timers_active--;
                     fired++;
                  end else begin
                     slot_rem[s] = 16'd1;
                     o.status    = STAT_FULL;
                  end
               end
            end
         end
      endcase
      o.fired_count = 4'(fired);
      o.queued_now  = 4'(ring_fill);
      o.queued_peak = 4'(ring_peak);
      o.timers_now  = 4'(timers_active);
      o.timers_peak = 4'(timers_high);
      return o;
   endfunction

   // ------------------------------------------------------------------
   // Driver: offers backlog entries; predicts at the accepting edge.
   // ------------------------------------------------------------------
   evq_cmd_type on_bus;
   evq_cmd_type cmd;

   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            on_bus = '{req_bus.kind, req_bus.event_id, req_bus.handler,
                       req_bus.delay, req_bus.timer_index};
            expected_results.push_back(advance_scheduler(on_bus));
            accepted++;
         end
         // only move on once the current offer is gone; valid gets one NBA per edge
         if (!req_bus.valid || req_bus.ready) begin
            if (command_backlog.size() != 0 &&
                (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
               cmd = command_backlog.pop_front();
               req_bus.valid       <= 1'b1;
               req_bus.kind        <= cmd.kind;
               req_bus.event_id    <= cmd.event_id;
               req_bus.handler     <= cmd.handler;
               req_bus.delay       <= cmd.delay;
               req_bus.timer_index <= cmd.timer_index;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Monitor: checks each result against the oldest prediction, and
   // drives ready (random idling, plus one long counted hold-off).
   // ------------------------------------------------------------------
   evq_result_type got;
   evq_result_type want;
   int             hold_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = '{rsp_bus.status, rsp_bus.timer_id, rsp_bus.out_event_id,
                    rsp_bus.out_handler, rsp_bus.fired_count, rsp_bus.queued_now,
                    rsp_bus.queued_peak, rsp_bus.timers_now, rsp_bus.timers_peak};
            n_checked++;
            if (got.status == STAT_FULL)    n_full++;
            if (got.status == STAT_NO_SLOT) n_no_slot++;
            if (got.status == STAT_ZERO_ID) n_zero_id++;
            n_fired += got.fired_count;
            if (expected_results.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("%0t: result %0d arrived with nothing outstanding", $realtime,
                           n_checked);
            end else begin
               want = expected_results.pop_front();
               if (got.status       !== want.status       ||
                   got.timer_id     !== want.timer_id     ||
                   got.out_event_id !== want.out_event_id ||
                   got.out_handler  !== want.out_handler  ||
                   got.fired_count  !== want.fired_count  ||
                   got.queued_now   !== want.queued_now   ||
                   got.queued_peak  !== want.queued_peak  ||
                   got.timers_now   !== want.timers_now   ||
                   got.timers_peak  !== want.timers_peak) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS) begin
                     $write("%0t: result %0d exp st=%0d tid=%0d ev=%02h hw=%04h",
                            $realtime, n_checked, want.status, want.timer_id,
                            want.out_event_id, want.out_handler);
                     $display(" fired=%0d q=%0d/%0d t=%0d/%0d", want.fired_count,
                              want.queued_now, want.queued_peak, want.timers_now,
                              want.timers_peak);
                     $write("%0t: result %0d got st=%0d tid=%0d ev=%02h hw=%04h",
                            $realtime, n_checked, got.status, got.timer_id,
                            got.out_event_id, got.out_handler);
                     $display(" fired=%0d q=%0d/%0d t=%0d/%0d", got.fired_count,
                              got.queued_now, got.queued_peak, got.timers_now,
                              got.timers_peak);
                  end
               end
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
         end
      end
   end

   // ------------------------------------------------------------------
   // Watchdog: any handshake on either channel counts as progress.
   // ------------------------------------------------------------------
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no transaction for %0d cycles, %0d results outstanding",
                     STALL_LIMIT, expected_results.size());
            $display("event_queue_timer_scheduler regression: fail");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   task automatic offer(input logic [1:0] kind, input logic [7:0] id,
                        input logic [15:0] hw, input logic [15:0] dl,
                        input logic [2:0] ti);
      command_backlog.push_back('{kind, id, hw, dl, ti});
      issued++;
   endtask

   // Wait until every queued command went in and every result came back.
   task automatic wait_drained();
      while (accepted != issued || command_backlog.size() != 0 ||
             expected_results.size() != 0)
         @(posedge clock);
   endtask

   // Register write, only called with the block idle.
   task automatic write_tick_interval(input logic [15:0] v);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      tick_iv = v;
   endtask

   // Delays mostly within a few ticks so timers actually expire.
   function automatic logic [15:0] pick_delay();
      int r;
      int d;
      r = $urandom_range(0, 9);
      if (r < 6)
         d = $urandom_range(1, 4) * ((tick_iv == 16'd0) ? 1 : int'(tick_iv))
             - $urandom_range(0, 1);
      else if (r < 9)
         d = $urandom_range(1, 16);
      else
         d = $urandom_range(1, 65535);
      if (d < 1)     d = 1;
      if (d > 65535) d = 65535;
      return 16'(d);
   endfunction

   // Random traffic as short sequences: ring bursts (some overflowing),
   // arm-then-tick groups, pop runs, cancels, plus raw noise.
   task automatic random_phase(input int n);
      int made;
      int pick;
      int len;
      int j;
      made = 0;
      while (made < n) begin
         pick = $urandom_range(0, 99);
         if (pick < 15) begin
            offer(2'($urandom), ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom),
                  16'($urandom), 16'($urandom), 3'($urandom));
            made++;
         end else if (pick < 33) begin
            len = $urandom_range(1, 18);
            for (j = 0; j < len; j++)
               offer(KIND_POST, 8'($urandom_range(1, 255)), 16'($urandom), 16'd0,
                     3'($urandom));
            made += len;
         end else if (pick < 60) begin
            len = $urandom_range(1, 9);
            for (j = 0; j < len; j++)
               offer(KIND_POST, 8'($urandom_range(1, 255)), 16'($urandom), pick_delay(),
                     3'($urandom));
            made += len;
            len = $urandom_range(1, 6);
            for (j = 0; j < len; j++)
               offer(KIND_TICK, 8'($urandom), 16'($urandom), 16'($urandom), 3'($urandom));
            made += len;
         end else if (pick < 76) begin
            len = $urandom_range(1, 10);
            for (j = 0; j < len; j++)
               offer(KIND_POP, 8'($urandom), 16'($urandom), 16'($urandom), 3'($urandom));
            made += len;
         end else if (pick < 86) begin
            len = $urandom_range(1, 3);
            for (j = 0; j < len; j++)
               offer(KIND_CANCEL, 8'($urandom), 16'($urandom), 16'($urandom), 3'($urandom));
            made += len;
         end else begin
            offer(KIND_TICK, 8'($urandom), 16'($urandom), 16'($urandom), 3'($urandom));
            made++;
         end
      end
   endtask

   initial begin
      logic [15:0] tick_plan [NUM_PHASES];
      int          phase;
      int          i;

      reset               = 1'b1;
      csr_wr_en           = 1'b0;
      csr_wr_data         = 16'd0;
      req_bus.valid       = 1'b0;
      req_bus.kind        = KIND_POP;
      req_bus.event_id    = 8'd0;
      req_bus.handler     = 16'd0;
      req_bus.delay       = 16'd0;
      req_bus.timer_index = 3'd0;
      rsp_bus.ready       = 1'b0;

      // both extremes, the zero interval that never expires, and a few in between
      tick_plan = '{16'hFFFF, 16'h0000, 16'h0001, 16'h0003, 16'h0000, 16'h0002};
      tick_plan[4] = 16'($urandom_range(4, 300));

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed part, tick_interval at its reset value of 1.
      offer(KIND_POP, 8'hFF, 16'hFFFF, 16'hFFFF, 3'd7);      // pop from an empty ring
      offer(KIND_POST, 8'd0, 16'hFFFF, 16'hFFFF, 3'd7);      // zero id is refused
      offer(KIND_POST, 8'hFF, 16'hFFFF, 16'd0, 3'd0);        // immediate, all ones
      offer(KIND_POST, 8'h01, 16'h0000, 16'd0, 3'd7);        // immediate, smallest id
      offer(KIND_POP, 8'd0, 16'd0, 16'd0, 3'd0);
      offer(KIND_POP, 8'd0, 16'd0, 16'd0, 3'd0);
      offer(KIND_POP, 8'd0, 16'd0, 16'd0, 3'd0);             // empty again
      // arm all eight slots; delays 1, max, 2, 3, 1, 1, mid, 1
      offer(KIND_POST, 8'h10, 16'h1234, 16'd1,     3'd0);
      offer(KIND_POST, 8'h11, 16'h5555, 16'hFFFF,  3'd0);
      offer(KIND_POST, 8'h12, 16'hAAAA, 16'd2,     3'd0);
      offer(KIND_POST, 8'h13, 16'h0F0F, 16'd3,     3'd0);
      offer(KIND_POST, 8'h14, 16'hF0F0, 16'd1,     3'd0);
      offer(KIND_POST, 8'h15, 16'h0001, 16'd1,     3'd0);
      offer(KIND_POST, 8'h16, 16'h8000, 16'h8000,  3'd0);
      offer(KIND_POST, 8'h17, 16'h7FFF, 16'd1,     3'd0);
      offer(KIND_POST, 8'h18, 16'hBEEF, 16'd5,     3'd0);    // no free slot
      offer(KIND_CANCEL, 8'hFF, 16'hFFFF, 16'hFFFF, 3'd7);   // frees the top slot
      offer(KIND_CANCEL, 8'd0, 16'd0, 16'd0, 3'd7);          // already free, ignored
      offer(KIND_CANCEL, 8'd0, 16'd0, 16'd0, 3'd0);
      offer(KIND_TICK, 8'd0, 16'd0, 16'd0, 3'd0);            // slots 4 and 5 fire
      offer(KIND_POST, 8'h19, 16'hC0DE, 16'd1, 3'd0);        // lowest free slot is 0
      offer(KIND_TICK, 8'hFF, 16'hFFFF, 16'hFFFF, 3'd7);
      offer(KIND_TICK, 8'd0, 16'd0, 16'd0, 3'd0);
      for (i = 0; i < 3; i++)
         offer(KIND_POP, 8'd0, 16'd0, 16'd0, 3'd0);
      wait_drained();

      for (phase = 0; phase < NUM_PHASES; phase++) begin
         write_tick_interval(tick_plan[phase]);
         steady = (phase == 3);            // one whole phase runs without idling
         random_phase(PHASE_ITEMS);
         if (phase == 2)
            hold_request = 1'b1;           // sender keeps offering into a stalled block
         wait_drained();                   // sender pauses until all results are in
      end
      steady = 1'b0;

      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d commands over %0d tick settings: %0d queue-full, %0d no-slot,",
               issued, NUM_PHASES + 1, n_full, n_no_slot);
      $display("  %0d zero-id results and %0d timer expiries; %0d results checked",
               n_zero_id, n_fired, n_checked);
      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("event_queue_timer_scheduler regression: pass");
      end else begin
         $display("%0d mismatches, %0d results outstanding", mismatches,
                  expected_results.size());
         $display("event_queue_timer_scheduler regression: fail");
      end
      $finish;
   end

endmodule

// ===== files.f =====
design/evq_pkg.sv
design/evq_if.sv
design/evq_ring.sv
design/event_queue_timer_scheduler.sv
sim/tb.sv
